@@ rtl/rpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types and constants of the record packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rpd_pkg;

    localparam int RECORD_MAX_DEF = 255;
    localparam int IMU_BYTES      = 36;
    localparam logic [7:0] IMU_CODE_RESET = 8'h50;

    // result kinds
    localparam logic [2:0] KIND_PACKET = 3'd0;
    localparam logic [2:0] KIND_TRUNC  = 3'd1;
    localparam logic [2:0] KIND_ACCEL  = 3'd2;
    localparam logic [2:0] KIND_GYRO   = 3'd3;
    localparam logic [2:0] KIND_SHORT  = 3'd4;
    localparam logic [2:0] KIND_TRAIL  = 3'd5;

    // binary32 scale factors, mantissa with hidden bit and biased exponent
    localparam logic [23:0] ACCEL_MANT = 24'h9CE80A;
    localparam logic [7:0]  ACCEL_EXP  = 8'd130;
    localparam logic [23:0] GYRO_MANT  = 24'h8EFA35;
    localparam logic [7:0]  GYRO_EXP   = 8'd121;

    // follow-up results of a queued job
    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_SHORT,
        EXTRA_IMU
    } extra_t;

    typedef struct packed {
        logic [2:0]  kind;
        extra_t      extra;
        logic [7:0]  start;
        logic [7:0]  ptype;
        logic [7:0]  seq;
        logic [7:0]  size;
        logic [7:0]  count;
        logic [63:0] ts;
        logic [31:0] meta;
        logic [95:0] accel;
        logic [95:0] gyro;
    } rpd_job_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  start;
        logic [7:0]  ptype;
        logic [7:0]  seq;
        logic [7:0]  size;
        logic [7:0]  count;
        logic [63:0] ts;
        logic [31:0] meta;
        logic        vec;
        logic        last;
    } rpd_res_t;

endpackage

`default_nettype wire

@@ rtl/rpd_front.sv @@
// ----------------------------------------------------------------------------
// rpd_front
// Byte parser: checks the record header, walks packets and queues one job
// per completed packet, truncated packet or leftover.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_front #(
    parameter int RECORD_MAX = rpd_pkg::RECORD_MAX_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire logic [7:0]       imu_code,
    input  wire logic             q_full,
    output logic                  q_push,
    output rpd_pkg::rpd_job_t     q_job
);
    import rpd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE,
        PH_SEQ,
        PH_LEN,
        PH_PAYLOAD,
        PH_DISCARD
    } phase_t;

    phase_t      phase_reg, phase_next, ph;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  hs_reg, hs_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  size_reg, size_next;
    logic [7:0]  start_reg, start_next;
    logic [7:0]  seen_reg, seen_next;
    logic [7:0]  store_reg [IMU_BYTES];
    logic [7:0]  store_nx  [IMU_BYTES];
    logic        wr_en;
    logic        acc;
    logic        gen;
    logic        complete;
    logic [8:0]  off_p1;

    function automatic logic [31:0] le32(input logic [7:0] s [IMU_BYTES], input int at);
        le32 = {s[at + 3], s[at + 2], s[at + 1], s[at]};
    endfunction

    assign s_ready = !q_full;
    assign acc     = s_valid && !q_full;
    assign q_push  = acc && gen;
    assign off_p1  = {1'b0, off_reg} + 9'd1;

    always_comb begin
        phase_next = phase_reg;
        off_next   = off_reg;
        hs_next    = hs_reg;
        type_next  = type_reg;
        seq_next   = seq_reg;
        size_next  = size_reg;
        start_next = start_reg;
        seen_next  = seen_reg;
        wr_en      = 1'b0;
        gen        = 1'b0;
        complete   = 1'b0;
        q_job      = '0;
        ph = ({1'b0, off_reg} >= 9'(RECORD_MAX)) ? PH_DISCARD : phase_reg;
        phase_next = ph;

        case (ph)
            PH_HEADER: begin
                if (off_reg == 8'd0) begin
                    if (data_byte != 8'd1) phase_next = PH_DISCARD;
                end else if (off_reg == 8'd1) begin
                    hs_next = data_byte;
                    if (data_byte < 8'd3) phase_next = PH_DISCARD;
                end else if (off_reg == 8'd2 && data_byte != 8'd0) begin
                    phase_next = PH_DISCARD;
                end
                if (phase_next == PH_HEADER && off_reg >= 8'd2 && off_p1 == {1'b0, hs_next})
                    phase_next = PH_TYPE;
            end
            PH_TYPE: begin
                start_next = off_reg;
                type_next  = data_byte;
                if (last_byte) begin
                    gen         = 1'b1;
                    q_job.kind  = KIND_TRAIL;
                    q_job.count = 8'd1;
                end
                phase_next = PH_SEQ;
            end
            PH_SEQ: begin
                seq_next = data_byte;
                if (last_byte) begin
                    gen         = 1'b1;
                    q_job.kind  = KIND_TRAIL;
                    q_job.count = 8'd2;
                end
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                size_next = data_byte;
                seen_next = 8'd0;
                if (data_byte == 8'd0) begin
                    complete   = 1'b1;
                    phase_next = PH_TYPE;
                end else begin
                    if (last_byte) begin
                        gen        = 1'b1;
                        q_job.kind = KIND_TRUNC;
                    end
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                wr_en     = (seen_reg < 8'(IMU_BYTES));
                seen_next = seen_reg + 8'd1;
                if (seen_next == size_reg) begin
                    complete   = 1'b1;
                    phase_next = PH_TYPE;
                end else if (last_byte) begin
                    gen         = 1'b1;
                    q_job.kind  = KIND_TRUNC;
                    q_job.count = seen_next;
                end
            end
            default: begin
                phase_next = PH_DISCARD;
            end
        endcase

        for (int k = 0; k < IMU_BYTES; k++) begin
            store_nx[k] = store_reg[k];
        end
        if (wr_en) store_nx[seen_reg[5:0]] = data_byte;

        if (complete) begin
            gen        = 1'b1;
            q_job.kind = KIND_PACKET;
            if (type_next != imu_code)
                q_job.extra = EXTRA_NONE;
            else if (size_next < 8'(IMU_BYTES))
                q_job.extra = EXTRA_SHORT;
            else
                q_job.extra = EXTRA_IMU;
        end
        q_job.start = start_next;
        q_job.ptype = type_next;
        q_job.seq   = seq_next;
        q_job.size  = size_next;
        q_job.ts    = {le32(store_nx, 4), le32(store_nx, 0)};
        q_job.meta  = le32(store_nx, 32);
        q_job.accel = {le32(store_nx, 16), le32(store_nx, 12), le32(store_nx, 8)};
        q_job.gyro  = {le32(store_nx, 28), le32(store_nx, 24), le32(store_nx, 20)};

        if ({1'b0, off_reg} < 9'(RECORD_MAX)) off_next = off_reg + 8'd1;
        if (last_byte) begin
            phase_next = PH_HEADER;
            off_next   = 8'd0;
            hs_next    = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            off_reg   <= '0;
            hs_reg    <= '0;
            type_reg  <= '0;
            seq_reg   <= '0;
            size_reg  <= '0;
            start_reg <= '0;
            seen_reg  <= '0;
        end else if (acc) begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            hs_reg    <= hs_next;
            type_reg  <= type_next;
            seq_reg   <= seq_next;
            size_reg  <= size_next;
            start_reg <= start_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && wr_en) store_reg[seen_reg[5:0]] <= data_byte;
    end

endmodule

`default_nettype wire

@@ rtl/rpd_queue.sv @@
// ----------------------------------------------------------------------------
// rpd_queue
// Small job queue between the parser and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire rpd_pkg::rpd_job_t wr_job,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output rpd_pkg::rpd_job_t      rd_job
);
    import rpd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rpd_job_t        mem_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     cnt_reg, cnt_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        bump = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full      = (cnt_reg == (AW+1)'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rd_job    = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + (AW+1)'(1);
        if (pop && !push) cnt_next = cnt_reg - (AW+1)'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= bump(wptr_reg);
            if (pop)  rptr_reg <= bump(rptr_reg);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

@@ rtl/rpd_fmul.sv @@
// ----------------------------------------------------------------------------
// rpd_fmul
// Three-stage binary32 multiply by one of two fixed factors, round to
// nearest even: mantissa product, normalize, denormal shift and round.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_fmul (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic        gyro_sel,
    output logic [31:0]      y
);
    import rpd_pkg::*;

    // stage 1
    logic               sgn1_reg, spec1_reg;
    logic [31:0]        sval1_reg;
    logic [47:0]        p1_reg;
    logic signed [9:0]  e1_reg;
    // stage 2
    logic               sgn2_reg, spec2_reg;
    logic [31:0]        sval2_reg;
    logic [47:0]        p2_reg;
    logic signed [9:0]  e2_reg;
    // stage 3
    logic [31:0]        y_reg;

    logic [7:0]         ea, ec, eeff;
    logic [22:0]        fa;
    logic [23:0]        ma, mc;
    logic               spec_in;
    logic [31:0]        sval_in;
    logic [5:0]         lz;
    logic [5:0]         sh;
    logic signed [9:0]  shd;
    logic [47:0]        xs, mask;
    logic               g, st, rnd;
    logic [7:0]         ef;
    logic [30:0]        mag;
    logic [31:0]        y_next;

    assign ea   = a[30:23];
    assign fa   = a[22:0];
    assign ma   = {ea != 8'd0, fa};
    assign eeff = (ea == 8'd0) ? 8'd1 : ea;
    assign mc   = gyro_sel ? GYRO_MANT : ACCEL_MANT;
    assign ec   = gyro_sel ? GYRO_EXP : ACCEL_EXP;

    always_comb begin
        spec_in = (ea == 8'hFF) || (ea == 8'd0 && fa == 23'd0);
        if (ea != 8'hFF)
            sval_in = {a[31], 31'd0};
        else if (fa != 23'd0)
            sval_in = a | 32'h0040_0000;
        else
            sval_in = a;
    end

    // leading zero count of the product
    always_comb begin
        lz = 6'd0;
        for (int k = 0; k < 48; k++) begin
            if (p1_reg[k]) lz = 6'(47 - k);
        end
    end

    always_comb begin
        shd  = (e2_reg <= 10'sd0) ? (10'sd1 - e2_reg) : 10'sd0;
        sh   = shd[5:0];
        xs   = p2_reg >> sh;
        mask = (48'd1 << sh) - 48'd1;
        g    = xs[23];
        st   = (|xs[22:0]) || (|(p2_reg & mask));
        rnd  = g && (st || xs[24]);
        ef   = (e2_reg > 10'sd0) ? e2_reg[7:0] : 8'd0;
        mag  = {ef, xs[46:24]} + 31'(rnd);
        if (spec2_reg)
            y_next = sval2_reg;
        else if (e2_reg > 10'sd254)
            y_next = {sgn2_reg, 8'hFF, 23'd0};
        else
            y_next = {sgn2_reg, mag};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sgn1_reg  <= a[31];
            spec1_reg <= spec_in;
            sval1_reg <= sval_in;
            p1_reg    <= {24'd0, ma} * {24'd0, mc};
            e1_reg    <= signed'(10'(eeff)) + signed'(10'(ec)) - 10'sd126;
            sgn2_reg  <= sgn1_reg;
            spec2_reg <= spec1_reg;
            sval2_reg <= sval1_reg;
            p2_reg    <= p1_reg << lz;
            e2_reg    <= e1_reg - signed'(10'(lz));
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

`default_nettype wire

@@ rtl/rpd_back.sv @@
// ----------------------------------------------------------------------------
// rpd_back
// Result sequencer: expands each queued job into one to three results and
// runs the IMU vectors through three multiply lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire rpd_pkg::rpd_job_t q_job,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rpd_pkg::rpd_res_t      m_res,
    output logic [95:0]            m_vec
);
    import rpd_pkg::*;

    logic [1:0]   sub_reg;
    logic [1:0]   last_sub;
    logic         adv, issue, at_last;
    logic         v1_reg, v2_reg, vout_reg;
    rpd_res_t     r1_reg, r2_reg, rout_reg;
    rpd_res_t     res0;
    logic [95:0]  vin;
    logic         gyro_sel;
    logic [31:0]  yx, yy, yz;

    always_comb begin
        case (q_job.extra)
            EXTRA_IMU:   last_sub = 2'd2;
            EXTRA_SHORT: last_sub = 2'd1;
            default:     last_sub = 2'd0;
        endcase
    end

    assign adv     = !vout_reg || m_ready;
    assign issue   = adv && q_valid;
    assign at_last = (sub_reg == last_sub);
    assign q_pop   = issue && at_last;
    assign gyro_sel = (sub_reg == 2'd2);
    assign vin     = gyro_sel ? q_job.gyro : q_job.accel;

    always_comb begin
        res0       = '0;
        res0.start = q_job.start;
        res0.ptype = q_job.ptype;
        res0.seq   = q_job.seq;
        res0.size  = q_job.size;
        res0.last  = at_last;
        if (sub_reg == 2'd0) begin
            res0.kind  = q_job.kind;
            res0.count = q_job.count;
        end else if (q_job.extra == EXTRA_SHORT) begin
            res0.kind  = KIND_SHORT;
            res0.count = q_job.size;
        end else begin
            res0.kind = gyro_sel ? KIND_GYRO : KIND_ACCEL;
            res0.vec  = 1'b1;
            res0.ts   = q_job.ts;
            res0.meta = q_job.meta;
        end
        // leftover bytes carry no packet header
        if (res0.kind == KIND_TRAIL) begin
            res0.ptype = '0;
            res0.seq   = '0;
            res0.size  = '0;
        end
    end

    rpd_fmul u_mul_x (.aclk(aclk), .en(adv), .a(vin[31:0]),  .gyro_sel(gyro_sel), .y(yx));
    rpd_fmul u_mul_y (.aclk(aclk), .en(adv), .a(vin[63:32]), .gyro_sel(gyro_sel), .y(yy));
    rpd_fmul u_mul_z (.aclk(aclk), .en(adv), .a(vin[95:64]), .gyro_sel(gyro_sel), .y(yz));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg  <= '0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else if (adv) begin
            if (issue) sub_reg <= at_last ? 2'd0 : sub_reg + 2'd1;
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            vout_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r1_reg   <= res0;
            r2_reg   <= r1_reg;
            rout_reg <= r2_reg;
        end
    end

    assign m_valid = vout_reg;
    assign m_res   = rout_reg;
    assign m_vec   = rout_reg.vec ? {yz, yy, yx} : 96'd0;

endmodule

`default_nettype wire

@@ rtl/record_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// record_packet_deframer
// Byte-serial record deframer with IMU sample decoding.
// ----------------------------------------------------------------------------
// Record bytes come in on the s_ stream, one byte per request, s_tlast on
// the final byte. Results leave on the m_ stream, m_tlast on the last result
// caused by one byte, m_tuser holding the result kind.
// cfg_data sets the packet type decoded as IMU; write it only while idle.
// cfg_ready is always high.
// One byte is taken per cycle while the job queue is not full. The parser
// pushes at most one job per byte into a four-entry queue; the sequencer
// expands a job into one to three results at one result per cycle when the
// output is not stalled, so an IMU packet (at least 39 bytes) and any other
// packet (at least 3 bytes) drain at the byte rate. From the byte to its
// first result, the job is queued at the accepting edge, then every result
// rides through the three-stage pipeline matching the float multiply lanes.
// When m_tready is low the result pipeline holds, the queue fills and then
// s_tready drops. Reset clears the parser to the record header state, empties
// the queue and the pipeline and sets the IMU type code to 0x50.
// ----------------------------------------------------------------------------
`default_nettype none

module record_packet_deframer #(
    parameter int RECORD_MAX = rpd_pkg::RECORD_MAX_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // data_byte
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [231:0]      m_tdata,   // packet_offset, packet_type, sequence_number,
                                         // payload_size, byte_count, imu_timestamp,
                                         // imu_metadata, vector_x, vector_y, vector_z
    output logic [2:0]        m_tuser,   // kind
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data   // imu_type_code
);
    import rpd_pkg::*;

    logic       [7:0] imu_code_reg;
    logic             q_push, q_full, q_pop, q_ne;
    rpd_job_t         job_in, job_out;
    rpd_res_t         res;
    logic      [95:0] vec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            imu_code_reg <= IMU_CODE_RESET;
        end else if (cfg_valid) begin
            imu_code_reg <= cfg_data;
        end
    end

    rpd_front #(.RECORD_MAX(RECORD_MAX)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_tvalid), .s_ready(s_tready),
        .data_byte(s_tdata), .last_byte(s_tlast),
        .imu_code(imu_code_reg),
        .q_full(q_full), .q_push(q_push), .q_job(job_in)
    );

    rpd_queue #(.DEPTH(4)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .wr_job(job_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .rd_job(job_out)
    );

    rpd_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_ne), .q_job(job_out), .q_pop(q_pop),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_res(res), .m_vec(vec)
    );

    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {vec, res.meta, res.ts, res.count, res.size, res.seq,
                      res.ptype, res.start};

endmodule

`default_nettype wire

@@ rtl/rpd_checker.sv @@
// ----------------------------------------------------------------------------
// rpd_checker
// Port-level checks of the record packet deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rpd_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [231:0] m_tdata,
    input wire logic [2:0]   m_tuser,
    input wire logic         m_tlast
);
    import rpd_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // accel is always followed by gyro of the same byte
    a_accel_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ACCEL |-> !m_tlast)
        else $error("accel result closes a run");

    a_gyro_after_accel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_ACCEL
        |=> !m_tvalid || m_tuser == KIND_GYRO)
        else $error("accel result not followed by gyro");

    // leftover count is one or two
    a_trail_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_TRAIL
        |-> (m_tdata[39:32] == 8'd1 || m_tdata[39:32] == 8'd2) && m_tlast)
        else $error("bad trailing result");

endmodule

bind record_packet_deframer rpd_checker u_rpd_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

`default_nettype wire
